FILE: sv/bvfg_pkg.sv
package bvfg_pkg;

    // field widths
    localparam int UV_W   = 23;
    localparam int PCT_W  = 7;
    localparam int LVL_W  = 3;
    localparam int PROD_W = PCT_W + UV_W;

    // configuration port
    localparam int APB_DW = 32;
    localparam int APB_AW = 4;

    // register indexes
    localparam logic [1:0] REG_FULL_UV      = 2'd0;
    localparam logic [1:0] REG_KNEE_UV      = 2'd1;
    localparam logic [1:0] REG_EMPTY_UV     = 2'd2;
    localparam logic [1:0] REG_KNEE_PERCENT = 2'd3;

    // register reset values
    localparam logic [UV_W-1:0]  FULL_UV_RST      = 23'd4200000;
    localparam logic [UV_W-1:0]  KNEE_UV_RST      = 23'd3800000;
    localparam logic [UV_W-1:0]  EMPTY_UV_RST     = 23'd3500000;
    localparam logic [PCT_W-1:0] KNEE_PERCENT_RST = 7'd20;

    // grading thresholds
    localparam logic [PCT_W-1:0] PCT_FULL        = 7'd100;
    localparam logic [PCT_W-1:0] PCT_HIGH_FROM   = 7'd60;
    localparam logic [PCT_W-1:0] PCT_NORMAL_FROM = 7'd20;
    localparam logic [PCT_W-1:0] PCT_LOW_FROM    = 7'd10;

    // level codes
    localparam logic [LVL_W-1:0] LVL_CRITICAL = 3'd0;
    localparam logic [LVL_W-1:0] LVL_LOW      = 3'd1;
    localparam logic [LVL_W-1:0] LVL_NORMAL   = 3'd2;
    localparam logic [LVL_W-1:0] LVL_HIGH     = 3'd3;
    localparam logic [LVL_W-1:0] LVL_FULL     = 3'd4;

    // controller commands
    typedef struct packed {
        logic load_sample;
        logic update;
        logic div_avg_start;
        logic avg_take;
        logic seg_eval;
        logic div_pct_start;
        logic pct_take;
    } cmd_t;

    // datapath status
    typedef struct packed {
        logic div_done;
        logic seg_direct;
    } status_t;

endpackage

FILE: sv/bvfg_div.sv
module bvfg_div #(
    parameter int DVD_W = 32,
    parameter int DVS_W = 23
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int STEPS = DVD_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0]   r1, r1_sub, r2, r2_sub;
    logic             ge1, ge2;
    logic [DVS_W-1:0] r1_keep;

    // two restoring steps per cycle
    always_comb
    begin
        r1       = {rem_reg, quo_reg[DVD_W-1]};
        ge1      = r1 >= {1'b0, dvs_reg};
        r1_sub   = r1 - {1'b0, dvs_reg};
        r1_keep  = ge1 ? r1_sub[DVS_W-1:0] : r1[DVS_W-1:0];
        r2       = {r1_keep, quo_reg[DVD_W-2]};
        ge2      = r2 >= {1'b0, dvs_reg};
        r2_sub   = r2 - {1'b0, dvs_reg};
        rem_next = ge2 ? r2_sub[DVS_W-1:0] : r2[DVS_W-1:0];
        quo_next = {quo_reg[DVD_W-3:0], ge1, ge2};
    end

    // operand and quotient shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CNT_W'(STEPS);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    // checks
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider not busy after start");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != '0))
        else $error("divider busy with zero step count");

endmodule

FILE: sv/bvfg_ctrl.sv
module bvfg_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  bvfg_pkg::status_t  status,
    output bvfg_pkg::cmd_t     cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_UPD      = 3'd1;
    localparam logic [2:0] S_AVG_GO   = 3'd2;
    localparam logic [2:0] S_AVG_WAIT = 3'd3;
    localparam logic [2:0] S_SEG      = 3'd4;
    localparam logic [2:0] S_PCT_GO   = 3'd5;
    localparam logic [2:0] S_PCT_WAIT = 3'd6;
    localparam logic [2:0] S_OUT      = 3'd7;

    logic [2:0] state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_sample = 1'b1;
                    state_next      = S_UPD;
                end
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_AVG_GO;
            end
            S_AVG_GO:
            begin
                cmd.div_avg_start = 1'b1;
                state_next        = S_AVG_WAIT;
            end
            S_AVG_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.avg_take = 1'b1;
                    state_next   = S_SEG;
                end
            end
            S_SEG:
            begin
                cmd.seg_eval = 1'b1;
                state_next   = status.seg_direct ? S_OUT : S_PCT_GO;
            end
            S_PCT_GO:
            begin
                cmd.div_pct_start = 1'b1;
                state_next        = S_PCT_WAIT;
            end
            S_PCT_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.pct_take = 1'b1;
                    state_next   = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    // checks
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output both open");
    a_accept_upd: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_UPD))
        else $error("input transfer not followed by update");
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped before transfer");

endmodule

FILE: sv/bvfg_datapath.sv
module bvfg_datapath #(
    parameter int WINDOW = 200
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bvfg_pkg::cmd_t               cmd,
    output bvfg_pkg::status_t            status,
    input  logic [bvfg_pkg::UV_W-1:0]    sample_uv,
    input  logic [bvfg_pkg::UV_W-1:0]    full_uv,
    input  logic [bvfg_pkg::UV_W-1:0]    knee_uv,
    input  logic [bvfg_pkg::UV_W-1:0]    empty_uv,
    input  logic [bvfg_pkg::PCT_W-1:0]   knee_percent,
    output logic [bvfg_pkg::UV_W-1:0]    avg_uv,
    output logic [bvfg_pkg::PCT_W-1:0]   capacity_percent,
    output logic [bvfg_pkg::LVL_W-1:0]   capacity_level
);

    localparam int UV_W   = bvfg_pkg::UV_W;
    localparam int PCT_W  = bvfg_pkg::PCT_W;
    localparam int PROD_W = bvfg_pkg::PROD_W;
    localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = UV_W + CNT_W;
    localparam int RAW_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;
    localparam int DIV_W  = RAW_W + (RAW_W % 2);

    logic [UV_W-1:0]  ring_mem [WINDOW];
    logic [UV_W-1:0]  rd_data_reg;
    logic [UV_W-1:0]  sample_reg;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [PTR_W-1:0] wr_pos_reg;
    logic             ring_full;

    logic [UV_W-1:0]  avg_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [UV_W-1:0]  seg_div_reg;
    logic             add_k_reg;
    logic [PCT_W-1:0] pct_reg;

    logic [PCT_W-1:0] k_clamp;
    logic             above_full, above_knee, above_empty;
    logic [PCT_W-1:0] mul_a;
    logic [UV_W-1:0]  mul_b;
    logic [UV_W-1:0]  seg_div;
    logic [PROD_W-1:0] prod;

    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [UV_W-1:0]  div_divisor;
    logic             div_busy;
    logic             div_done;
    logic [DIV_W-1:0] div_quo;

    assign ring_full = (cnt_reg == CNT_W'(WINDOW));

    // sample ring, registered read of the oldest slot
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            ring_mem[wr_pos_reg] <= sample_reg;
        end
        rd_data_reg <= ring_mem[wr_pos_reg];
    end

    // running sum: add the new sample, drop the oldest once the ring is full
    always_comb
    begin
        sum_next = sum_reg + SUM_W'(sample_reg);
        if (ring_full)
        begin
            sum_next = sum_next - SUM_W'(rd_data_reg);
        end
    end

    // window bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            cnt_reg    <= '0;
            wr_pos_reg <= '0;
        end
        else if (cmd.update)
        begin
            sum_reg <= sum_next;
            if (!ring_full)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (wr_pos_reg == PTR_W'(WINDOW - 1))
            begin
                wr_pos_reg <= '0;
            end
            else
            begin
                wr_pos_reg <= wr_pos_reg + 1'b1;
            end
        end
    end

    // segment selection and numerator product
    always_comb
    begin
        k_clamp     = (knee_percent > bvfg_pkg::PCT_FULL) ? bvfg_pkg::PCT_FULL : knee_percent;
        above_full  = avg_reg > full_uv;
        above_knee  = avg_reg > knee_uv;
        above_empty = avg_reg > empty_uv;
        if (above_knee)
        begin
            mul_a   = bvfg_pkg::PCT_FULL - k_clamp;
            mul_b   = avg_reg - knee_uv;
            seg_div = full_uv - knee_uv;
        end
        else
        begin
            mul_a   = k_clamp;
            mul_b   = avg_reg - empty_uv;
            seg_div = knee_uv - empty_uv;
        end
        prod = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    assign status.seg_direct = above_full || (!above_knee && !above_empty);
    assign status.div_done   = div_done;

    // shared divider operands
    assign div_start    = cmd.div_avg_start || cmd.div_pct_start;
    assign div_dividend = cmd.div_avg_start ? DIV_W'(sum_reg) : DIV_W'(prod_reg);
    assign div_divisor  = cmd.div_avg_start ? UV_W'(cnt_reg) : seg_div_reg;

    bvfg_div #(
        .DVD_W (DIV_W),
        .DVS_W (UV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            sample_reg <= sample_uv;
        end
        if (cmd.avg_take)
        begin
            avg_reg <= div_quo[UV_W-1:0];
        end
        if (cmd.seg_eval)
        begin
            prod_reg    <= prod;
            seg_div_reg <= seg_div;
            add_k_reg   <= above_knee;
            if (status.seg_direct)
            begin
                pct_reg <= above_full ? bvfg_pkg::PCT_FULL : '0;
            end
        end
        if (cmd.pct_take)
        begin
            pct_reg <= (add_k_reg ? k_clamp : '0) + div_quo[PCT_W-1:0];
        end
    end

    // grading
    always_comb
    begin
        if (pct_reg >= bvfg_pkg::PCT_FULL)
        begin
            capacity_level = bvfg_pkg::LVL_FULL;
        end
        else if (pct_reg >= bvfg_pkg::PCT_HIGH_FROM)
        begin
            capacity_level = bvfg_pkg::LVL_HIGH;
        end
        else if (pct_reg >= bvfg_pkg::PCT_NORMAL_FROM)
        begin
            capacity_level = bvfg_pkg::LVL_NORMAL;
        end
        else if (pct_reg >= bvfg_pkg::PCT_LOW_FROM)
        begin
            capacity_level = bvfg_pkg::LVL_LOW;
        end
        else
        begin
            capacity_level = bvfg_pkg::LVL_CRITICAL;
        end
    end

    assign avg_uv           = avg_reg;
    assign capacity_percent = pct_reg;

    // checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(WINDOW))
        else $error("fill count beyond window");
    a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (sum_reg == '0))
        else $error("running sum nonzero with empty ring");
    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

endmodule

FILE: sv/battery_voltage_fuel_gauge.sv
// flow: input transfer, ring update, mean division, segment selection, percent division
//   and result valid; the percent division is skipped when the mean is above full or
//   at or below empty; one item in flight, the next input is accepted only once the
//   last result has been taken
// reset: asynchronous active low; sum, fill count, write slot and configuration
//   registers return to defaults, ring contents are only read after being written
module battery_voltage_fuel_gauge #(
    parameter int WINDOW = 200
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [bvfg_pkg::UV_W-1:0]         sample_uv,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bvfg_pkg::UV_W-1:0]         avg_uv,
    output logic [bvfg_pkg::PCT_W-1:0]        capacity_percent,
    output logic [bvfg_pkg::LVL_W-1:0]        capacity_level,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bvfg_pkg::APB_AW-1:0]       paddr,
    input  logic [bvfg_pkg::APB_DW-1:0]       pwdata,
    output logic [bvfg_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);

    logic [bvfg_pkg::UV_W-1:0]  full_uv_reg;
    logic [bvfg_pkg::UV_W-1:0]  knee_uv_reg;
    logic [bvfg_pkg::UV_W-1:0]  empty_uv_reg;
    logic [bvfg_pkg::PCT_W-1:0] knee_percent_reg;
    logic                       cfg_wr;
    logic [1:0]                 cfg_idx;

    bvfg_pkg::cmd_t    cmd;
    bvfg_pkg::status_t status;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_uv_reg      <= bvfg_pkg::FULL_UV_RST;
            knee_uv_reg      <= bvfg_pkg::KNEE_UV_RST;
            empty_uv_reg     <= bvfg_pkg::EMPTY_UV_RST;
            knee_percent_reg <= bvfg_pkg::KNEE_PERCENT_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                bvfg_pkg::REG_FULL_UV:      full_uv_reg      <= pwdata[bvfg_pkg::UV_W-1:0];
                bvfg_pkg::REG_KNEE_UV:      knee_uv_reg      <= pwdata[bvfg_pkg::UV_W-1:0];
                bvfg_pkg::REG_EMPTY_UV:     empty_uv_reg     <= pwdata[bvfg_pkg::UV_W-1:0];
                bvfg_pkg::REG_KNEE_PERCENT: knee_percent_reg <= pwdata[bvfg_pkg::PCT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (cfg_idx)
            bvfg_pkg::REG_FULL_UV:      prdata = bvfg_pkg::APB_DW'(full_uv_reg);
            bvfg_pkg::REG_KNEE_UV:      prdata = bvfg_pkg::APB_DW'(knee_uv_reg);
            bvfg_pkg::REG_EMPTY_UV:     prdata = bvfg_pkg::APB_DW'(empty_uv_reg);
            bvfg_pkg::REG_KNEE_PERCENT: prdata = bvfg_pkg::APB_DW'(knee_percent_reg);
            default:                    prdata = '0;
        endcase
    end

    bvfg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    bvfg_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .sample_uv        (sample_uv),
        .full_uv          (full_uv_reg),
        .knee_uv          (knee_uv_reg),
        .empty_uv         (empty_uv_reg),
        .knee_percent     (knee_percent_reg),
        .avg_uv           (avg_uv),
        .capacity_percent (capacity_percent),
        .capacity_level   (capacity_level)
    );

endmodule
